[hdl/osa_pkg.sv]
// Shared types and codes for the optimal-string-alignment distance block.
// No dependencies; used by osa_edit_distance.
package osa_pkg;

  // Item kinds carried on the input tuser field.
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Reset value of the gap limit register.
  localparam logic [5:0] GAP_LIMIT_RESET = 6'd2;

  // Largest distance that the 6-bit result field can carry.
  localparam int DIST_SAT = 63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_DRAIN,
    ST_EMIT
  } osa_state_t;

endpackage

[hdl/osa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies; instantiated for the word stores and the grid rows.
module osa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/osa_edit_distance.sv]
// Top level of the optimal-string-alignment edit distance block.
// Depends on osa_pkg (types, codes) and osa_ram (word stores and grid rows).

// The block collects two byte words, one character per input transfer (tuser
// kind 0 appends to the first word, kind 1 to the second), and on an end
// transfer (kind 2) returns one result: the optimal-string-alignment distance,
// where insertion, deletion, substitution and a swap of two adjacent
// characters each cost one. Character transfers are accepted even while an
// earlier result still waits on the output. When the word lengths differ by
// more than gap_limit, or one word is empty, the grid is skipped and the
// result goes straight to the emit state; otherwise a single cell unit
// evaluates one grid cell per cycle, reading the previous two rows from their
// own memories and writing the current row into a third, with a row setup
// state before each row. No input is taken while the grid runs. Characters
// beyond MAX_LEN are dropped and flagged in word_overflow; gap_exceeded
// reports a computation skipped for the gap limit, with distance 0.
// Distances above 63 saturate. Both words are emptied after every result.
module osa_edit_distance #(
  parameter int MAX_LEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  // Input stream.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic [1:0] s_tuser,   // [1:0] kind
  // Result stream.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [5:0] distance, [7:6] zero
  output logic [1:0] m_tuser,   // [0] gap_exceeded, [1] word_overflow
  // Gap limit register write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  // Lengths and distances both span 0..MAX_LEN; row memories hold MAX_LEN+1
  // entries and are addressed by column index with the same width.
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int WAW = $clog2(MAX_LEN);

  osa_pkg::osa_state_t state, state_next;

  // Control strobes decoded from the state.
  logic accept_in;
  logic load_first;
  logic load_second;
  logic start_end;
  logic row_setup;
  logic cell_issue;
  logic emit_now;

  // Word bookkeeping and configuration.
  logic [LW-1:0] first_len;
  logic [LW-1:0] second_len;
  logic          overflow_seen;
  logic [5:0]    gap_limit;
  logic [LW-1:0] len_diff;
  logic          gap_hit;
  logic          empty_word;

  // Grid position of the cell being issued and the row memory roles.
  logic [LW-1:0] row_i;
  logic [LW-1:0] col_j;
  logic [1:0]    rc;
  logic [1:0]    rc_setup;
  logic [1:0]    ob_sel;
  logic [1:0]    tb_sel;
  logic [LW-1:0] col_jm2;
  logic          last_col;
  logic          last_row;

  // Second stage: the cell whose reads were issued in the previous cycle.
  logic          b_valid;
  logic [LW-1:0] b_i;
  logic [LW-1:0] b_j;
  logic [1:0]    b_wram;
  logic [1:0]    b_ob;
  logic [1:0]    b_tb;
  logic          b_last;

  // Values carried from cell to cell and from row to row.
  logic [LW-1:0] ob_prev;   // previous row, column j-1
  logic [LW-1:0] cur_prev;  // current row, column j-1
  logic [7:0]    s_prev;    // second word, character j-2
  logic [7:0]    fw_prev;   // first word, character i-2

  // Memory read data.
  logic [7:0]    fw_rd;
  logic [7:0]    sw_rd;
  logic [LW-1:0] row_rd [3];

  // Cell arithmetic.
  logic [LW-1:0] ob_j;
  logic [LW-1:0] tb_v;
  logic [LW:0]   sub_cost;
  logic [LW:0]   del_cost;
  logic [LW:0]   ins_cost;
  logic [LW:0]   swp_cost;
  logic [LW:0]   best_w;
  logic [LW-1:0] best;
  logic          swap_ok;

  // Result holding register.
  logic [LW-1:0] res_dist;
  logic          res_gap;
  logic [5:0]    dist_sat;

  assign cfg_ready = 1'b1;
  assign accept_in = s_tvalid && s_tready;

  // Length difference against the gap limit decides whether the grid runs.
  assign len_diff   = (first_len > second_len) ? (first_len - second_len)
                                               : (second_len - first_len);
  assign gap_hit    = 32'(len_diff) > 32'(gap_limit);
  assign empty_word = (first_len == '0) || (second_len == '0);

  assign last_col = (col_j == second_len);
  assign last_row = (row_i == first_len);

  // ------------------------------------------------------------------
  // Next-state logic.
  // ------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      osa_pkg::ST_IDLE: begin
        if (accept_in && s_tuser == osa_pkg::KIND_END) begin
          if (gap_hit || empty_word) begin
            state_next = osa_pkg::ST_EMIT;
          end else begin
            state_next = osa_pkg::ST_ROW;
          end
        end
      end
      osa_pkg::ST_ROW: begin
        state_next = osa_pkg::ST_CELL;
      end
      osa_pkg::ST_CELL: begin
        if (last_col) begin
          state_next = last_row ? osa_pkg::ST_DRAIN : osa_pkg::ST_ROW;
        end
      end
      osa_pkg::ST_DRAIN: begin
        state_next = osa_pkg::ST_EMIT;
      end
      osa_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = osa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = osa_pkg::ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Output decode of the state machine.
  // ------------------------------------------------------------------
  always_comb begin
    s_tready    = 1'b0;
    load_first  = 1'b0;
    load_second = 1'b0;
    start_end   = 1'b0;
    row_setup   = 1'b0;
    cell_issue  = 1'b0;
    emit_now    = 1'b0;
    case (state)
      osa_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        load_first  = s_tvalid && s_tuser == osa_pkg::KIND_FIRST;
        load_second = s_tvalid && s_tuser == osa_pkg::KIND_SECOND;
        start_end   = s_tvalid && s_tuser == osa_pkg::KIND_END;
      end
      osa_pkg::ST_ROW: begin
        row_setup = 1'b1;
      end
      osa_pkg::ST_CELL: begin
        cell_issue = 1'b1;
      end
      osa_pkg::ST_DRAIN: begin
        cell_issue = 1'b0;
      end
      osa_pkg::ST_EMIT: begin
        emit_now = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= osa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ------------------------------------------------------------------
  // Gap limit register and word lengths.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= osa_pkg::GAP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gap_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_len     <= '0;
      second_len    <= '0;
      overflow_seen <= 1'b0;
    end else if (emit_now) begin
      first_len     <= '0;
      second_len    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (load_first) begin
        if (32'(first_len) < MAX_LEN) begin
          first_len <= first_len + LW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (load_second) begin
        if (32'(second_len) < MAX_LEN) begin
          second_len <= second_len + LW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  // Word stores. The first word is read once per row, the second once per cell.
  osa_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LEN)
  ) u_first_word (
    .clk  (clk),
    .we   (load_first && 32'(first_len) < MAX_LEN),
    .waddr(first_len[WAW-1:0]),
    .wdata(s_tdata),
    .re   (row_setup),
    .raddr(WAW'(row_i - LW'(1))),
    .rdata(fw_rd)
  );

  osa_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LEN)
  ) u_second_word (
    .clk  (clk),
    .we   (load_second && 32'(second_len) < MAX_LEN),
    .waddr(second_len[WAW-1:0]),
    .wdata(s_tdata),
    .re   (cell_issue),
    .raddr(WAW'(col_j - LW'(1))),
    .rdata(sw_rd)
  );

  // ------------------------------------------------------------------
  // Grid sequencing. The three row memories rotate roles every row: rc holds
  // the current row, rc-1 the row above and rc+1 the row two above.
  // ------------------------------------------------------------------
  assign rc_setup = (row_i == LW'(1)) ? 2'd0 : ((rc == 2'd2) ? 2'd0 : rc + 2'd1);
  assign ob_sel   = (rc == 2'd0) ? 2'd2 : rc - 2'd1;
  assign tb_sel   = (rc == 2'd2) ? 2'd0 : rc + 2'd1;
  assign col_jm2  = (col_j < LW'(2)) ? '0 : col_j - LW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_i <= '0;
      col_j <= '0;
      rc    <= 2'd0;
    end else begin
      if (start_end) begin
        row_i <= LW'(1);
      end else if (cell_issue && last_col && !last_row) begin
        row_i <= row_i + LW'(1);
      end
      if (row_setup) begin
        col_j <= LW'(1);
        rc    <= rc_setup;
      end else if (cell_issue) begin
        col_j <= col_j + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= cell_issue;
    end
  end

  always_ff @(posedge clk) begin
    b_i    <= row_i;
    b_j    <= col_j;
    b_wram <= rc;
    b_ob   <= ob_sel;
    b_tb   <= tb_sel;
    b_last <= last_col && last_row;
  end

  // Row memories. The setup cycle writes column zero of the new row while the
  // cell stage finishes the old row in a different memory.
  for (genvar k = 0; k < 3; k++) begin : g_row
    logic          we_k;
    logic [LW-1:0] waddr_k;
    logic [LW-1:0] wdata_k;
    logic          setup_k;

    assign setup_k = row_setup && rc_setup == 2'(k);
    assign we_k    = setup_k || (b_valid && b_wram == 2'(k));
    assign waddr_k = setup_k ? '0 : b_j;
    assign wdata_k = setup_k ? row_i : best;

    osa_ram #(
      .WIDTH(LW),
      .DEPTH(MAX_LEN + 1)
    ) u_row (
      .clk  (clk),
      .we   (we_k),
      .waddr(waddr_k),
      .wdata(wdata_k),
      .re   (cell_issue),
      .raddr((ob_sel == 2'(k)) ? col_j : col_jm2),
      .rdata(row_rd[k])
    );
  end

  // ------------------------------------------------------------------
  // Cell unit. Row zero is the column index itself, so the first two rows
  // take their upper neighbors from the index instead of a memory.
  // ------------------------------------------------------------------
  assign ob_j     = (b_i == LW'(1)) ? b_j : row_rd[b_ob];
  assign tb_v     = (b_i == LW'(2)) ? b_j - LW'(2) : row_rd[b_tb];
  assign sub_cost = {1'b0, ob_prev} + ((fw_rd == sw_rd) ? '0 : (LW + 1)'(1));
  assign del_cost = {1'b0, ob_j} + (LW + 1)'(1);
  assign ins_cost = {1'b0, cur_prev} + (LW + 1)'(1);
  assign swp_cost = {1'b0, tb_v} + (LW + 1)'(1);
  assign swap_ok  = (b_i > LW'(1)) && (b_j > LW'(1)) &&
                    (fw_rd == s_prev) && (fw_prev == sw_rd);

  always_comb begin
    best_w = (del_cost < ins_cost) ? del_cost : ins_cost;
    if (sub_cost < best_w) begin
      best_w = sub_cost;
    end
    if (swap_ok && swp_cost < best_w) begin
      best_w = swp_cost;
    end
  end

  assign best = best_w[LW-1:0];

  // Row setup takes priority: the last cell of a row has no successor there.
  always_ff @(posedge clk) begin
    if (row_setup) begin
      ob_prev  <= row_i - LW'(1);
      cur_prev <= row_i;
      fw_prev  <= fw_rd;
    end else if (b_valid) begin
      ob_prev  <= ob_j;
      cur_prev <= best;
    end
    if (b_valid) begin
      s_prev <= sw_rd;
    end
  end

  // ------------------------------------------------------------------
  // Result register and output stage.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (start_end) begin
      res_gap  <= gap_hit;
      res_dist <= gap_hit ? '0 : (first_len | second_len);
    end else if (b_valid && b_last) begin
      res_dist <= best;
    end
  end

  assign dist_sat = (32'(res_dist) > osa_pkg::DIST_SAT) ? 6'(osa_pkg::DIST_SAT)
                                                        : 6'(res_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_now) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      m_tdata <= {2'b00, dist_sat};
      m_tuser <= {overflow_seen, res_gap};
    end
  end

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != osa_pkg::ST_IDLE) |-> !s_tready)
    else $error("input accepted while the grid is busy");

  a_setup_port_free: assert property (@(posedge clk) disable iff (rst)
    (row_setup && b_valid) |-> (rc_setup != b_wram))
    else $error("row setup and cell write hit the same row memory");

  a_len_bounded: assert property (@(posedge clk) disable iff (rst)
    (32'(first_len) <= MAX_LEN) && (32'(second_len) <= MAX_LEN))
    else $error("word length beyond MAX_LEN");

  a_gap_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0))
    else $error("skipped computation reports a nonzero distance");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == osa_pkg::ST_EMIT))
    else $error("result raised outside the emit state");

endmodule
